[sv/utf8_char_indexed_string_pool_core_assert.svh]
// Assertion macros shared by the string pool RTL.
`ifndef UTF8_CHAR_INDEXED_STRING_POOL_CORE_ASSERT_SVH
`define UTF8_CHAR_INDEXED_STRING_POOL_CORE_ASSERT_SVH

// Same-cycle implication.
`define UCISP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ucisp: same-cycle check failed");

// Next-cycle implication.
`define UCISP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ucisp: next-cycle check failed");

`endif

[sv/ucisp_pkg.sv]
`default_nettype none

package ucisp_pkg;

    localparam int IDX_W  = 12;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 3;

    localparam logic [1:0] MODE_APPEND  = 2'd0;
    localparam logic [1:0] MODE_CLOSE   = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;
    localparam logic [1:0] MODE_COMPARE = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] index_a;
        logic [IDX_W-1:0] index_b;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0]  start_index;
        logic [CODE_W-1:0] char_code;
        logic [LEN_W-1:0]  char_len;
        logic              chars_equal;
        logic [1:0]        status;
    } out_t;

endpackage

`default_nettype wire

[sv/ucisp_ram.sv]
`default_nettype none

module ucisp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[sv/utf8_char_indexed_string_pool_core.sv]
// UTF-8 string pool with a character offset index.
// Input channel s_valid/s_ready/s_data carries one command per transaction:
// append byte, close string, read character, compare two characters.
// Result channel m_valid/m_ready/m_data returns exactly one result per command.
// Append, close, a bad index and a compare of equal indices finish at acceptance: the
// result is registered on the next edge and, while the output register is free, the
// next command can be taken in the next cycle, so byte appends stream at one per cycle
// while m_ready keeps up. A read fetches the start and end offsets of its character,
// then its len = 1..4 bytes; a compare of distinct indices does so for index_a, then
// for index_b. Both walk the offset table and the byte pool through the single
// registered read port of each memory. Reset (aresetn, synchronous, active low) empties
// the pool and the index at once; the memories need no clearing pass. A result waiting
// on a stalled m_ready holds in the output register; appends and closes are still
// accepted while the output register is empty or draining, and a finished result parks
// in a holding register until the output register frees up.
`default_nettype none

`include "utf8_char_indexed_string_pool_core_assert.svh"

module utf8_char_indexed_string_pool_core #(
    parameter int POOL_BYTES = 4096,
    parameter int CHAR_SLOTS = 4096
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire ucisp_pkg::in_t  s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output ucisp_pkg::out_t      m_data
);

    localparam int IDX_W = ucisp_pkg::IDX_W;
    localparam int CNT_W = $clog2(CHAR_SLOTS + 1);
    localparam int WP_W  = $clog2(POOL_BYTES + 1);
    localparam int OFF_W = $clog2(4 * CHAR_SLOTS + 1);
    localparam int PA_W  = $clog2(POOL_BYTES);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int IW1   = CMP_W + 1;
    localparam int PC_W  = ((OFF_W + 1) > WP_W) ? (OFF_W + 1) : WP_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_OFF0 = 6'b000010,
        S_OFF1 = 6'b000100,
        S_OFF2 = 6'b001000,
        S_BYTE = 6'b010000,
        S_RESP = 6'b100000
    } state_t;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd1;
        if (b[7] == 1'b0) begin
            n = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            n = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            n = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            n = 3'd4;
        end
        return n;
    endfunction

    state_t            state_reg, state_next;
    logic [WP_W-1:0]   wp_reg, wp_next;
    logic [CNT_W-1:0]  cc_reg, cc_next;
    logic [1:0]        skip_reg, skip_next;
    logic              open_reg, open_next;
    logic [IDX_W-1:0]  start_reg, start_next;
    logic [OFF_W-1:0]  last_off_reg, last_off_next;
    logic [1:0]        mode_reg, mode_next;
    logic [IDX_W-1:0]  ia_reg, ia_next;
    logic [IDX_W-1:0]  ib_reg, ib_next;
    logic              phase_reg, phase_next;
    logic [OFF_W-1:0]  s_off_reg, s_off_next;
    logic [2:0]        len_reg, len_next;
    logic [2:0]        len_a_reg, len_a_next;
    logic [2:0]        iss_reg, iss_next;
    logic [2:0]        rcv_reg, rcv_next;
    logic [31:0]       code_reg, code_next;
    logic [31:0]       code_a_reg, code_a_next;
    logic              bvld_reg, bvld_next;
    logic              binr_reg, binr_next;
    logic              off_zero_reg;
    logic              m_valid_reg, m_valid_next;
    ucisp_pkg::out_t   m_data_reg, m_data_next;
    ucisp_pkg::out_t   resp_reg, resp_next;

    ucisp_pkg::out_t   res;
    logic              res_valid;
    logic              slot_free;
    logic              s_fire;
    logic              lead;
    logic              app_full;
    logic              cls_full;
    logic              a_bad;
    logic              b_bad;
    logic [2:0]        n_len;
    logic [IDX_W-1:0]  cur_idx;
    logic [OFF_W-1:0]  off_val;
    logic [PC_W-1:0]   byte_addr;
    logic [31:0]       code_shift;

    logic              pool_we;
    logic [PA_W-1:0]   pool_waddr;
    logic [7:0]        pool_wdata;
    logic [PA_W-1:0]   pool_raddr;
    logic [7:0]        pool_rdata;
    logic              off_we;
    logic [CNT_W-1:0]  off_waddr;
    logic [OFF_W-1:0]  off_wdata;
    logic [CNT_W-1:0]  off_raddr;
    logic [OFF_W-1:0]  off_rdata;

    ucisp_ram #(
        .WIDTH (8),
        .DEPTH (POOL_BYTES)
    ) u_pool (
        .clk     (aclk),
        .wr_en   (pool_we),
        .wr_addr (pool_waddr),
        .wr_data (pool_wdata),
        .rd_addr (pool_raddr),
        .rd_data (pool_rdata)
    );

    ucisp_ram #(
        .WIDTH (OFF_W),
        .DEPTH (CHAR_SLOTS + 1)
    ) u_offsets (
        .clk     (aclk),
        .wr_en   (off_we),
        .wr_addr (off_waddr),
        .wr_data (off_wdata),
        .rd_addr (off_raddr),
        .rd_data (off_rdata)
    );

    assign s_ready    = (state_reg == S_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign slot_free  = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    assign lead       = (skip_reg == 2'd0);
    assign app_full   = (wp_reg >= WP_W'(POOL_BYTES - 1)) ||
                        (lead && (cc_reg >= CNT_W'(CHAR_SLOTS - 1)));
    assign cls_full   = (wp_reg >= WP_W'(POOL_BYTES)) || (cc_reg >= CNT_W'(CHAR_SLOTS));
    assign a_bad      = CMP_W'(s_data.index_a) >= CMP_W'(cc_reg);
    assign b_bad      = CMP_W'(s_data.index_b) >= CMP_W'(cc_reg);
    assign n_len      = lead_len(s_data.data_byte);

    assign cur_idx    = phase_reg ? ib_reg : ia_reg;
    assign off_val    = off_zero_reg ? '0 : off_rdata;
    assign byte_addr  = PC_W'(s_off_reg) + PC_W'(iss_reg);
    assign pool_raddr = PA_W'(byte_addr);
    assign code_shift = {code_reg[23:0], (binr_reg ? pool_rdata : 8'h00)};

    always_comb begin
        unique case (state_reg)
            S_IDLE:  off_raddr = CNT_W'(s_data.index_a);
            S_OFF0:  off_raddr = CNT_W'(ib_reg);
            default: off_raddr = CNT_W'(IW1'(cur_idx) + IW1'(1));
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        cc_next       = cc_reg;
        skip_next     = skip_reg;
        open_next     = open_reg;
        start_next    = start_reg;
        last_off_next = last_off_reg;
        mode_next     = mode_reg;
        ia_next       = ia_reg;
        ib_next       = ib_reg;
        phase_next    = phase_reg;
        s_off_next    = s_off_reg;
        len_next      = len_reg;
        len_a_next    = len_a_reg;
        iss_next      = iss_reg;
        rcv_next      = rcv_reg;
        code_next     = code_reg;
        code_a_next   = code_a_reg;
        bvld_next     = 1'b0;
        binr_next     = binr_reg;
        resp_next     = resp_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        res           = '0;
        res_valid     = 1'b0;
        pool_we       = 1'b0;
        pool_waddr    = PA_W'(wp_reg);
        pool_wdata    = s_data.data_byte;
        off_we        = 1'b0;
        off_waddr     = CNT_W'(cc_reg + CNT_W'(1));
        off_wdata     = OFF_W'(last_off_reg + OFF_W'(n_len));

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.mode)
                        ucisp_pkg::MODE_APPEND: begin
                            res_valid = 1'b1;
                            if (app_full) begin
                                res.status = ucisp_pkg::ST_FULL;
                            end else begin
                                if (!open_reg) begin
                                    open_next  = 1'b1;
                                    start_next = IDX_W'(cc_reg);
                                end
                                if (lead) begin
                                    off_we        = 1'b1;
                                    last_off_next = off_wdata;
                                    cc_next       = cc_reg + CNT_W'(1);
                                    skip_next     = 2'(n_len - 3'd1);
                                end else begin
                                    skip_next = skip_reg - 2'd1;
                                end
                                pool_we = 1'b1;
                                wp_next = wp_reg + WP_W'(1);
                            end
                        end
                        ucisp_pkg::MODE_CLOSE: begin
                            res_valid = 1'b1;
                            if (cls_full) begin
                                res.status = ucisp_pkg::ST_FULL;
                            end else begin
                                res.start_index = open_reg ? start_reg : IDX_W'(cc_reg);
                                pool_we       = 1'b1;
                                pool_wdata    = 8'h00;
                                wp_next       = wp_reg + WP_W'(1);
                                off_we        = 1'b1;
                                off_wdata     = last_off_reg + OFF_W'(1);
                                last_off_next = last_off_reg + OFF_W'(1);
                                cc_next       = cc_reg + CNT_W'(1);
                                open_next     = 1'b0;
                                skip_next     = 2'd0;
                            end
                        end
                        ucisp_pkg::MODE_READ: begin
                            if (a_bad) begin
                                res_valid  = 1'b1;
                                res.status = ucisp_pkg::ST_BAD_INDEX;
                            end else begin
                                mode_next  = s_data.mode;
                                ia_next    = s_data.index_a;
                                ib_next    = s_data.index_b;
                                phase_next = 1'b0;
                                state_next = S_OFF1;
                            end
                        end
                        ucisp_pkg::MODE_COMPARE: begin
                            if (a_bad || b_bad) begin
                                res_valid  = 1'b1;
                                res.status = ucisp_pkg::ST_BAD_INDEX;
                            end else if (s_data.index_a == s_data.index_b) begin
                                res_valid       = 1'b1;
                                res.chars_equal = 1'b1;
                            end else begin
                                mode_next  = s_data.mode;
                                ia_next    = s_data.index_a;
                                ib_next    = s_data.index_b;
                                phase_next = 1'b0;
                                state_next = S_OFF1;
                            end
                        end
                    endcase
                end
            end
            S_OFF0: begin
                state_next = S_OFF1;
            end
            S_OFF1: begin
                s_off_next = off_val;
                state_next = S_OFF2;
            end
            S_OFF2: begin
                len_next   = 3'(off_val - s_off_reg);
                iss_next   = 3'd0;
                rcv_next   = 3'd0;
                code_next  = '0;
                state_next = S_BYTE;
            end
            S_BYTE: begin
                if (iss_reg != len_reg) begin
                    bvld_next = 1'b1;
                    binr_next = byte_addr < PC_W'(wp_reg);
                    iss_next  = iss_reg + 3'd1;
                end
                if (bvld_reg) begin
                    code_next = code_shift;
                    rcv_next  = rcv_reg + 3'd1;
                    if (3'(rcv_reg + 3'd1) == len_reg) begin
                        if (mode_reg == ucisp_pkg::MODE_READ) begin
                            res_valid     = 1'b1;
                            res.char_code = code_shift;
                            res.char_len  = len_reg;
                        end else if (!phase_reg) begin
                            code_a_next = code_shift;
                            len_a_next  = len_reg;
                            phase_next  = 1'b1;
                            state_next  = S_OFF0;
                        end else begin
                            res_valid       = 1'b1;
                            res.chars_equal = (len_reg == len_a_reg) &&
                                              (code_shift == code_a_reg);
                        end
                    end
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = resp_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (res_valid) begin
            if (slot_free) begin
                m_valid_next = 1'b1;
                m_data_next  = res;
                state_next   = S_IDLE;
            end else begin
                resp_next  = res;
                state_next = S_RESP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            wp_reg       <= '0;
            cc_reg       <= '0;
            skip_reg     <= '0;
            open_reg     <= 1'b0;
            start_reg    <= '0;
            last_off_reg <= '0;
            bvld_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            cc_reg       <= cc_next;
            skip_reg     <= skip_next;
            open_reg     <= open_next;
            start_reg    <= start_next;
            last_off_reg <= last_off_next;
            bvld_reg     <= bvld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        ia_reg       <= ia_next;
        ib_reg       <= ib_next;
        phase_reg    <= phase_next;
        s_off_reg    <= s_off_next;
        len_reg      <= len_next;
        len_a_reg    <= len_a_next;
        iss_reg      <= iss_next;
        rcv_reg      <= rcv_next;
        code_reg     <= code_next;
        code_a_reg   <= code_a_next;
        binr_reg     <= binr_next;
        off_zero_reg <= (off_raddr == '0);
        resp_reg     <= resp_next;
        m_data_reg   <= m_data_next;
    end

    `UCISP_ASSERT_NXT(a_wp_step, aclk, aresetn, s_fire && (s_data.mode == ucisp_pkg::MODE_APPEND) && !app_full, wp_reg == $past(wp_reg) + WP_W'(1))
    `UCISP_ASSERT_IMP(a_skip_open, aclk, aresetn, skip_reg != 2'd0, open_reg)
    `UCISP_ASSERT_IMP(a_byte_count, aclk, aresetn, state_reg == S_BYTE, (rcv_reg < len_reg) && (iss_reg <= len_reg))
    `UCISP_ASSERT_IMP(a_resp_parked, aclk, aresetn, state_reg == S_RESP, m_valid_reg)

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int POOL_BYTES  = 4096;
    localparam int CHAR_SLOTS  = 4096;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        ucisp_pkg::in_t  cmd;
        ucisp_pkg::out_t want;
        bit              hold;
    } pool_cmd_t;

    logic            aclk    = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    ucisp_pkg::in_t  s_data  = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    ucisp_pkg::out_t m_data;

    // shadow copy of the pool and its character index
    logic [7:0]  pool_mirror [POOL_BYTES];
    logic [13:0] char_offsets [CHAR_SLOTS + 1];
    logic [12:0] pool_fill;
    logic [12:0] char_total;
    logic [1:0]  cont_left;
    bit          str_active;
    logic [11:0] str_first;

    pool_cmd_t       command_queue [$];
    ucisp_pkg::out_t pending_results [$];
    pool_cmd_t       on_bus;
    ucisp_pkg::out_t want;
    bit        hold_next = 1'b0;
    int        commands_sent = 0;
    int        results_seen = 0;
    int        mismatches = 0;
    int        stall_cycles = 0;
    int        mode_tally [4] = '{default: 0};
    int        status_tally [4] = '{default: 0};

    utf8_char_indexed_string_pool_core dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
    );

    always #5 aclk = ~aclk;

    function automatic int utf8_len(logic [7:0] b);
        if (!b[7]) return 1;
        if (b[7:5] == 3'b110) return 2;
        if (b[7:4] == 4'b1110) return 3;
        if (b[7:3] == 5'b11110) return 4;
        return 1;
    endfunction

    function automatic logic [7:0] stored_byte(int addr);
        if (addr < int'(pool_fill) && addr < POOL_BYTES) return pool_mirror[addr];
        return 8'h00;
    endfunction

    function automatic ucisp_pkg::out_t pool_result(ucisp_pkg::in_t cmd);
        ucisp_pkg::out_t r;
        int   n, sa, sb, la, lb, k;
        bit   lead;
        r = '0;
        case (cmd.mode)
            ucisp_pkg::MODE_APPEND: begin
                lead = (cont_left == 2'd0);
                if (int'(pool_fill) + 1 >= POOL_BYTES ||
                    (lead && int'(char_total) + 1 >= CHAR_SLOTS)) begin
                    r.status = ucisp_pkg::ST_FULL;
                end else begin
                    if (!str_active) begin
                        str_active = 1'b1;
                        str_first  = char_total[11:0];
                    end
                    if (lead) begin
                        n = utf8_len(cmd.data_byte);
                        char_offsets[char_total + 1] = char_offsets[char_total] + 14'(n);
                        char_total++;
                        cont_left = 2'(n - 1);
                    end else begin
                        cont_left--;
                    end
                    pool_mirror[pool_fill] = cmd.data_byte;
                    pool_fill++;
                end
            end
            ucisp_pkg::MODE_CLOSE: begin
                if (int'(pool_fill) >= POOL_BYTES || int'(char_total) >= CHAR_SLOTS) begin
                    r.status = ucisp_pkg::ST_FULL;
                end else begin
                    r.start_index = str_active ? str_first : char_total[11:0];
                    pool_mirror[pool_fill] = 8'h00;
                    pool_fill++;
                    char_offsets[char_total + 1] = char_offsets[char_total] + 14'd1;
                    char_total++;
                    str_active = 1'b0;
                    cont_left  = 2'd0;
                end
            end
            ucisp_pkg::MODE_READ: begin
                if (int'(cmd.index_a) >= int'(char_total)) begin
                    r.status = ucisp_pkg::ST_BAD_INDEX;
                end else begin
                    sa = char_offsets[cmd.index_a];
                    la = int'(char_offsets[cmd.index_a + 1]) - sa;
                    r.char_len = 3'(la);
                    for (k = 0; k < la; k++)
                        r.char_code = {r.char_code[23:0], stored_byte(sa + k)};
                end
            end
            ucisp_pkg::MODE_COMPARE: begin
                if (int'(cmd.index_a) >= int'(char_total) ||
                    int'(cmd.index_b) >= int'(char_total)) begin
                    r.status = ucisp_pkg::ST_BAD_INDEX;
                end else if (cmd.index_a == cmd.index_b) begin
                    r.chars_equal = 1'b1;
                end else begin
                    sa = char_offsets[cmd.index_a];
                    sb = char_offsets[cmd.index_b];
                    la = int'(char_offsets[cmd.index_a + 1]) - sa;
                    lb = int'(char_offsets[cmd.index_b + 1]) - sb;
                    r.chars_equal = (la == lb);
                    for (k = 0; r.chars_equal && k < la; k++)
                        if (stored_byte(sa + k) != stored_byte(sb + k)) r.chars_equal = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    task automatic push_cmd(logic [1:0] mode, logic [7:0] b, logic [11:0] ia,
                            logic [11:0] ib);
        pool_cmd_t rec;
        rec.cmd.mode      = mode;
        rec.cmd.data_byte = b;
        rec.cmd.index_a   = ia;
        rec.cmd.index_b   = ib;
        rec.want          = pool_result(rec.cmd);
        rec.hold          = hold_next;
        hold_next         = 1'b0;
        mode_tally[mode]++;
        status_tally[rec.want.status]++;
        command_queue.insert(command_queue.size(), rec);
    endtask

    task automatic append_byte(logic [7:0] b);
        push_cmd(ucisp_pkg::MODE_APPEND, b, 12'($urandom), 12'($urandom));
    endtask

    task automatic close_string();
        push_cmd(ucisp_pkg::MODE_CLOSE, 8'($urandom), 12'($urandom), 12'($urandom));
    endtask

    task automatic read_char(logic [11:0] ia);
        push_cmd(ucisp_pkg::MODE_READ, 8'($urandom), ia, 12'($urandom));
    endtask

    task automatic compare_chars(logic [11:0] ia, logic [11:0] ib);
        push_cmd(ucisp_pkg::MODE_COMPARE, 8'($urandom), ia, ib);
    endtask

    function automatic logic [7:0] lead_byte(int n);
        case (n)
            1:       return 8'($urandom_range(0, 127));
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic logic [11:0] pick_index();
        int r;
        r = $urandom_range(99);
        if (char_total != 0 && r < 85) return 12'($urandom_range(0, int'(char_total) - 1));
        if (r < 92) return char_total[11:0];
        return 12'($urandom);
    endfunction

    // a small alphabet makes equal characters at different indices common
    task automatic append_char(bit few);
        int n, k;
        if (few) begin
            case ($urandom_range(3))
                0: append_byte(8'h61);
                1: append_byte(8'h62);
                2: begin
                    append_byte(8'hC3);
                    append_byte(8'hA9);
                end
                default: begin
                    append_byte(8'hE2);
                    append_byte(8'h82);
                    append_byte(8'hAC);
                end
            endcase
        end else begin
            n = $urandom_range(1, 4);
            append_byte(lead_byte(n));
            for (k = 1; k < n; k++) append_byte(cont_byte());
        end
    endtask

    task automatic append_broken_char();
        int n, k, m;
        case ($urandom_range(2))
            0: begin
                n = $urandom_range(2, 4);
                m = $urandom_range(0, n - 2);
                append_byte(lead_byte(n));
                for (k = 0; k < m; k++) append_byte(cont_byte());
            end
            1:       append_byte(cont_byte());
            default: append_byte({5'b11111, 3'($urandom)});
        endcase
    endtask

    function automatic bit quiet_stretch();
        return commands_sent >= 500 && commands_sent < 900;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid       <= 1'b0;
            commands_sent <= 0;
        end else begin
            if (s_valid && s_ready) begin
                pending_results.insert(pending_results.size(), on_bus.want);
                commands_sent <= commands_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (command_queue.size() != 0 &&
                    (quiet_stretch() || $urandom_range(99) >= 30) &&
                    (!command_queue[0].hold || (!s_valid && commands_sent == results_seen)))
                begin
                    on_bus = command_queue.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= on_bus.cmd;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            results_seen <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no transaction pending: %p", $time, m_data);
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.start_index !== want.start_index ||
                        m_data.char_code !== want.char_code ||
                        m_data.char_len !== want.char_len ||
                        m_data.chars_equal !== want.chars_equal ||
                        m_data.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: result %0d expected start %0d code %h len %0d ",
                                      "eq %0d status %0d, got start %0d code %h len %0d ",
                                      "eq %0d status %0d"},
                                     $time, results_seen, want.start_index, want.char_code,
                                     want.char_len, want.chars_equal, want.status,
                                     m_data.start_index, m_data.char_code, m_data.char_len,
                                     m_data.chars_equal, m_data.status);
                    end
                end
            end
            m_ready <= quiet_stretch() || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("utf8_char_indexed_string_pool_core: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int r, k, n, total;
        pool_fill       = '0;
        char_total      = '0;
        cont_left       = '0;
        str_active      = 1'b0;
        str_first       = '0;
        char_offsets[0] = '0;

        // directed: empty pool, every character length, invalid leads, truncation
        read_char(12'd0);
        close_string();
        append_byte(8'h41);
        append_byte(8'h00);
        append_byte(8'hFF);
        append_byte(8'hC3);
        append_byte(8'hA9);
        append_byte(8'hE2);
        append_byte(8'h82);
        append_byte(8'hAC);
        append_byte(8'hF0);
        append_byte(8'h9F);
        append_byte(8'h98);
        append_byte(8'h80);
        append_byte(8'h80);
        close_string();
        append_byte(8'hF0);
        append_byte(8'h7F);
        read_char(12'd9);
        close_string();
        read_char(12'd6);
        compare_chars(12'd6, 12'd6);
        compare_chars(12'd3, 12'd7);
        compare_chars(12'd1, 12'hFFF);
        compare_chars(12'd0, 12'd8);

        hold_next = 1'b1;
        while (command_queue.size() < 1300) begin
            if ($urandom_range(249) == 0) hold_next = 1'b1;
            r = $urandom_range(99);
            if (r < 55) begin
                n = $urandom_range(0, 6);
                for (k = 0; k < n; k++) begin
                    if ($urandom_range(9) == 0) append_broken_char();
                    else append_char($urandom_range(9) < 4);
                end
                if ($urandom_range(9) != 0) close_string();
            end else if (r < 75) begin
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++) read_char(pick_index());
            end else if (r < 92) begin
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++) begin
                    if ($urandom_range(4) == 0) begin
                        r = pick_index();
                        compare_chars(12'(r), 12'(r));
                    end else begin
                        compare_chars(pick_index(), pick_index());
                    end
                end
            end else begin
                push_cmd(2'($urandom), 8'($urandom), 12'($urandom), 12'($urandom));
            end
        end

        // probe the top of the index
        hold_next = 1'b1;
        read_char(12'(int'(char_total) - 1));
        read_char(12'(int'(char_total) - 2));
        compare_chars(12'(int'(char_total) - 2), 12'(int'(char_total) - 2));
        compare_chars(12'(int'(char_total) - 1), 12'd0);
        read_char(char_total[11:0]);
        read_char(12'hFFF);
        for (k = 0; k < 20; k++) begin
            read_char(pick_index());
            compare_chars(pick_index(), pick_index());
        end
        total = command_queue.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        while (results_seen != total) @(posedge aclk);
        repeat (40) @(posedge aclk);
        mismatches += pending_results.size();

        $display("%0d transactions: %0d appends, %0d closes, %0d reads, %0d compares",
                 total, mode_tally[ucisp_pkg::MODE_APPEND],
                 mode_tally[ucisp_pkg::MODE_CLOSE],
                 mode_tally[ucisp_pkg::MODE_READ], mode_tally[ucisp_pkg::MODE_COMPARE]);
        $display("%0d full and %0d bad-index results; pool ended at %0d bytes, %0d chars",
                 status_tally[ucisp_pkg::ST_FULL], status_tally[ucisp_pkg::ST_BAD_INDEX],
                 pool_fill, char_total);
        if (mismatches == 0) begin
            $display("utf8_char_indexed_string_pool_core: match");
        end else begin
            $display("utf8_char_indexed_string_pool_core: mismatch");
        end
        $finish;
    end

endmodule

[utf8_char_indexed_string_pool_core.f]
+incdir+sv
sv/ucisp_pkg.sv
sv/ucisp_ram.sv
sv/utf8_char_indexed_string_pool_core.sv
verif/testbench.sv
